@@ rtl/core/fieldbus_telegram_receiver_assert.svh @@
// Assertion helpers shared by the deframer RTL.
`ifndef FIELDBUS_TELEGRAM_RECEIVER_ASSERT_SVH
`define FIELDBUS_TELEGRAM_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FTR_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, checked outside reset.
`define FTR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

@@ rtl/core/ftr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ftr_pkg;

    // delimiters and fixed codes on the bus
    localparam logic [7:0] START_FIXED = 8'h10;
    localparam logic [7:0] START_VAR   = 8'h68;
    localparam logic [7:0] START_LONG  = 8'hA2;
    localparam logic [7:0] START_TOKEN = 8'hDC;
    localparam logic [7:0] SHORT_ACK   = 8'hE5;
    localparam logic [7:0] END_DELIM   = 8'h16;
    localparam logic [7:0] LONG_REST   = 8'd13;
    localparam logic [7:0] TOKEN_REST  = 8'd2;
    localparam logic [7:0] FIXED_REST  = 8'd5;
    localparam logic [7:0] MIN_LENGTH  = 8'd3;

    localparam int unsigned ADDR_W = 7;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_FIXED = 2'd1;
    localparam logic [1:0] KIND_VAR   = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_START   = 3'd1;
    localparam logic [2:0] ST_BAD_HEADER  = 3'd2;
    localparam logic [2:0] ST_BAD_END     = 3'd3;
    localparam logic [2:0] ST_BAD_SUM     = 3'd4;
    localparam logic [2:0] ST_ADDR        = 3'd5;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd6;
    localparam logic [2:0] ST_TIMEOUT     = 3'd7;

    localparam logic CFG_MASTER_ADDRESS   = 1'b0;
    localparam logic CFG_EXPECTED_STATION = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic [1:0] frame_kind;
        logic [7:0] function_code;
        logic [2:0] status;
        logic [7:0] payload_length;
    } ftr_result_t;

endpackage

`default_nettype wire

@@ rtl/core/fieldbus_telegram_receiver.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "fieldbus_telegram_receiver_assert.svh"

// Byte-serial receiver for fieldbus reply telegrams. One received character enters per
// cycle unless the output stalls; it is held in the input register, checked by the
// single-pass deframer logic, and its word, if it makes one, is registered in the
// output register. A payload byte of a variable frame comes out with last = 0 as soon as
// it arrives; every frame closes with one last = 1 word whose status says whether the
// streamed bytes can be kept. While the output is stalled the input register still
// takes one more character.
// Write master_address (index 0) and expected_station (index 1) only while idle.
module fieldbus_telegram_receiver
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [7:0]                 rx_byte,
    input  wire logic                       gap_expired,

    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [7:0]                      data_byte,
    output logic                            last,
    output logic [1:0]                      frame_kind,
    output logic [7:0]                      function_code,
    output logic [2:0]                      status,
    output logic [7:0]                      payload_length,

    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic                       cfg_index,
    input  wire logic [ftr_pkg::ADDR_W-1:0] cfg_data
);

    logic                        in_valid_reg, in_valid_next;
    logic [7:0]                  in_byte_reg;
    logic                        in_gap_reg;
    logic                        out_valid_reg, out_valid_next;
    ftr_pkg::ftr_result_t        res_reg;
    logic [ftr_pkg::ADDR_W-1:0]  master_reg, expected_reg;

    logic                        advance;
    logic                        res_valid;
    ftr_pkg::ftr_result_t        res;

    // the held word moves on whenever the output register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = res_valid;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            master_reg    <= ftr_pkg::ADDR_W'(1);
            expected_reg  <= ftr_pkg::ADDR_W'(2);
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ftr_pkg::CFG_MASTER_ADDRESS:   master_reg   <= cfg_data;
                    ftr_pkg::CFG_EXPECTED_STATION: expected_reg <= cfg_data;
                    default:                       master_reg   <= master_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
            in_gap_reg  <= gap_expired;
        end
        if (advance && res_valid)
            res_reg <= res;
    end

    ftr_deframer u_deframer
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_en          (advance),
        .rx_byte          (in_byte_reg),
        .gap_expired      (in_gap_reg),
        .master_address   (master_reg),
        .expected_station (expected_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    assign out_valid      = out_valid_reg;
    assign data_byte      = res_reg.data_byte;
    assign last           = res_reg.last;
    assign frame_kind     = res_reg.frame_kind;
    assign function_code  = res_reg.function_code;
    assign status         = res_reg.status;
    assign payload_length = res_reg.payload_length;

    `FTR_ASSERT_IMPLIES(a_stall_blocks_input, clk, rst_n, in_valid_reg && out_valid_reg && !out_ready, !in_ready)
    `FTR_ASSERT_IMPLIES(a_report_no_data, clk, rst_n, out_valid_reg && res_reg.last, res_reg.data_byte == 8'd0)
    `FTR_ASSERT_IMPLIES(a_payload_word_var, clk, rst_n, out_valid_reg && !res_reg.last, (res_reg.frame_kind == ftr_pkg::KIND_VAR) && (res_reg.payload_length != 8'd0))

endmodule

`default_nettype wire

@@ rtl/core/ftr_deframer.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "fieldbus_telegram_receiver_assert.svh"

module ftr_deframer
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step_en,
    input  wire logic [7:0]                 rx_byte,
    input  wire logic                       gap_expired,
    input  wire logic [ftr_pkg::ADDR_W-1:0] master_address,
    input  wire logic [ftr_pkg::ADDR_W-1:0] expected_station,
    output logic                            res_valid,
    output ftr_pkg::ftr_result_t            res
);

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_FIXED      = 4'd1;
    localparam logic [3:0] PH_LEN1       = 4'd2;
    localparam logic [3:0] PH_LEN2       = 4'd3;
    localparam logic [3:0] PH_SD2        = 4'd4;
    localparam logic [3:0] PH_BODY       = 4'd5;
    localparam logic [3:0] PH_FCS        = 4'd6;
    localparam logic [3:0] PH_END        = 4'd7;
    localparam logic [3:0] PH_SKIP_LONG  = 4'd8;
    localparam logic [3:0] PH_SKIP_TOKEN = 4'd9;

    logic [3:0] phase_reg, phase_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] length_copy_reg, length_copy_next;
    logic [7:0] sum_reg, sum_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] dest_reg, dest_next;
    logic [7:0] src_reg, src_next;
    logic [7:0] func_reg, func_next;
    logic [7:0] body_index_reg, body_index_next;
    logic [7:0] payload_count_reg, payload_count_next;

    logic [7:0] data_start;

    // address extension bits push the first payload byte back
    assign data_start = 8'd3 + {7'd0, dest_reg[7]} + {7'd0, src_reg[7]};

    always_comb
    begin
        phase_next         = phase_reg;
        bytes_left_next    = bytes_left_reg;
        frame_length_next  = frame_length_reg;
        length_copy_next   = length_copy_reg;
        sum_next           = sum_reg;
        kind_next          = kind_reg;
        dest_next          = dest_reg;
        src_next           = src_reg;
        func_next          = func_reg;
        body_index_next    = body_index_reg;
        payload_count_next = payload_count_reg;

        res_valid          = 1'b0;
        res.data_byte      = 8'd0;
        res.last           = 1'b1;
        res.frame_kind     = kind_reg;
        res.function_code  = 8'd0;
        res.status         = ftr_pkg::ST_OK;
        res.payload_length = payload_count_reg;

        if (gap_expired)
        begin
            if (phase_reg != PH_IDLE)
            begin
                res_valid         = 1'b1;
                res.function_code = func_reg;
                res.status        = ftr_pkg::ST_TIMEOUT;
                phase_next        = PH_IDLE;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    // every start byte opens a fresh frame context
                    bytes_left_next    = 8'd0;
                    frame_length_next  = 8'd0;
                    length_copy_next   = 8'd0;
                    sum_next           = 8'd0;
                    dest_next          = 8'd0;
                    src_next           = 8'd0;
                    func_next          = 8'd0;
                    body_index_next    = 8'd0;
                    payload_count_next = 8'd0;
                    res.payload_length = 8'd0;
                    priority if (rx_byte == ftr_pkg::SHORT_ACK)
                    begin
                        kind_next      = ftr_pkg::KIND_ACK;
                        res_valid      = 1'b1;
                        res.frame_kind = ftr_pkg::KIND_ACK;
                    end
                    else if (rx_byte == ftr_pkg::START_FIXED)
                    begin
                        kind_next       = ftr_pkg::KIND_FIXED;
                        bytes_left_next = ftr_pkg::FIXED_REST;
                        phase_next      = PH_FIXED;
                    end
                    else if (rx_byte == ftr_pkg::START_VAR)
                    begin
                        kind_next  = ftr_pkg::KIND_VAR;
                        phase_next = PH_LEN1;
                    end
                    else if (rx_byte == ftr_pkg::START_LONG)
                    begin
                        kind_next       = ftr_pkg::KIND_OTHER;
                        bytes_left_next = ftr_pkg::LONG_REST;
                        phase_next      = PH_SKIP_LONG;
                    end
                    else if (rx_byte == ftr_pkg::START_TOKEN)
                    begin
                        kind_next       = ftr_pkg::KIND_OTHER;
                        bytes_left_next = ftr_pkg::TOKEN_REST;
                        phase_next      = PH_SKIP_TOKEN;
                    end
                    else
                    begin
                        kind_next      = ftr_pkg::KIND_OTHER;
                        res_valid      = 1'b1;
                        res.frame_kind = ftr_pkg::KIND_OTHER;
                        res.status     = ftr_pkg::ST_BAD_START;
                    end
                end

                PH_FIXED:
                begin
                    if (body_index_reg == 8'd0)
                        dest_next = rx_byte;
                    else if (body_index_reg == 8'd1)
                        src_next = rx_byte;
                    else if (body_index_reg == 8'd2)
                        func_next = rx_byte;
                    if (body_index_reg < 8'd3)
                        sum_next = sum_reg + rx_byte;
                    else if (body_index_reg == 8'd3)
                        sum_next = sum_reg - rx_byte;
                    body_index_next = body_index_reg + 8'd1;
                    bytes_left_next = bytes_left_reg - 8'd1;
                    if (bytes_left_next == 8'd0)
                    begin
                        res_valid         = 1'b1;
                        res.frame_kind    = ftr_pkg::KIND_FIXED;
                        res.function_code = func_next;
                        phase_next        = PH_IDLE;
                        if (rx_byte != ftr_pkg::END_DELIM)
                            res.status = ftr_pkg::ST_BAD_END;
                        else if (sum_next != 8'd0)
                            res.status = ftr_pkg::ST_BAD_SUM;
                    end
                end

                PH_LEN1:
                begin
                    frame_length_next = rx_byte;
                    phase_next        = PH_LEN2;
                end

                PH_LEN2:
                begin
                    length_copy_next = rx_byte;
                    phase_next       = PH_SD2;
                end

                PH_SD2:
                begin
                    if (frame_length_reg != length_copy_reg || rx_byte != ftr_pkg::START_VAR
                        || frame_length_reg < ftr_pkg::MIN_LENGTH)
                    begin
                        res_valid      = 1'b1;
                        res.frame_kind = ftr_pkg::KIND_VAR;
                        res.status     = ftr_pkg::ST_BAD_HEADER;
                        phase_next     = PH_IDLE;
                    end
                    else
                    begin
                        bytes_left_next = frame_length_reg;
                        phase_next      = PH_BODY;
                    end
                end

                PH_BODY:
                begin
                    if (body_index_reg == 8'd0)
                        dest_next = rx_byte;
                    else if (body_index_reg == 8'd1)
                        src_next = rx_byte;
                    else if (body_index_reg == 8'd2)
                        func_next = rx_byte;
                    else if (body_index_reg >= data_start)
                    begin
                        payload_count_next = payload_count_reg + 8'd1;
                        res_valid          = 1'b1;
                        res.data_byte      = rx_byte;
                        res.last           = 1'b0;
                        res.frame_kind     = ftr_pkg::KIND_VAR;
                        res.function_code  = func_reg;
                        res.payload_length = payload_count_next;
                    end
                    sum_next        = sum_reg + rx_byte;
                    body_index_next = body_index_reg + 8'd1;
                    bytes_left_next = bytes_left_reg - 8'd1;
                    if (bytes_left_next == 8'd0)
                        phase_next = PH_FCS;
                end

                PH_FCS:
                begin
                    sum_next   = sum_reg - rx_byte;
                    phase_next = PH_END;
                end

                PH_END:
                begin
                    res_valid         = 1'b1;
                    res.frame_kind    = ftr_pkg::KIND_VAR;
                    res.function_code = func_reg;
                    phase_next        = PH_IDLE;
                    if (rx_byte != ftr_pkg::END_DELIM)
                        res.status = ftr_pkg::ST_BAD_END;
                    else if (sum_reg != 8'd0)
                        res.status = ftr_pkg::ST_BAD_SUM;
                    else if (dest_reg[ftr_pkg::ADDR_W-1:0] != master_address
                             || src_reg[ftr_pkg::ADDR_W-1:0] != expected_station)
                        res.status = ftr_pkg::ST_ADDR;
                end

                PH_SKIP_LONG:
                begin
                    bytes_left_next = bytes_left_reg - 8'd1;
                    if (bytes_left_next == 8'd0)
                    begin
                        res_valid      = 1'b1;
                        res.frame_kind = ftr_pkg::KIND_OTHER;
                        res.status     = (rx_byte != ftr_pkg::END_DELIM) ?
                                         ftr_pkg::ST_BAD_END : ftr_pkg::ST_UNSUPPORTED;
                        phase_next     = PH_IDLE;
                    end
                end

                PH_SKIP_TOKEN:
                begin
                    bytes_left_next = bytes_left_reg - 8'd1;
                    if (bytes_left_next == 8'd0)
                    begin
                        res_valid      = 1'b1;
                        res.frame_kind = ftr_pkg::KIND_OTHER;
                        res.status     = ftr_pkg::ST_UNSUPPORTED;
                        phase_next     = PH_IDLE;
                    end
                end

                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bytes_left_reg    <= 8'd0;
            frame_length_reg  <= 8'd0;
            length_copy_reg   <= 8'd0;
            sum_reg           <= 8'd0;
            kind_reg          <= ftr_pkg::KIND_ACK;
            dest_reg          <= 8'd0;
            src_reg           <= 8'd0;
            func_reg          <= 8'd0;
            body_index_reg    <= 8'd0;
            payload_count_reg <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            bytes_left_reg    <= bytes_left_next;
            frame_length_reg  <= frame_length_next;
            length_copy_reg   <= length_copy_next;
            sum_reg           <= sum_next;
            kind_reg          <= kind_next;
            dest_reg          <= dest_next;
            src_reg           <= src_next;
            func_reg          <= func_next;
            body_index_reg    <= body_index_next;
            payload_count_reg <= payload_count_next;
        end
    end

    `FTR_ASSERT_NEXT(a_report_returns_idle, clk, rst_n, step_en && res_valid && res.last, phase_reg == PH_IDLE)
    `FTR_ASSERT_IMPLIES(a_body_min_length, clk, rst_n, phase_reg == PH_BODY, frame_length_reg >= ftr_pkg::MIN_LENGTH)
    `FTR_ASSERT_IMPLIES(a_fixed_index_range, clk, rst_n, phase_reg == PH_FIXED, body_index_reg < ftr_pkg::FIXED_REST)

endmodule

`default_nettype wire
